FILE: sv/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms used by the checker of the token
// serialiser.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while in reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cts_pkg.sv
`default_nettype none
// ============================================================================
// CBOR token serialiser package
// Token codes, CBOR head constants and the encoded-word bundle type.
// ============================================================================
package cts_pkg;

    localparam int MAX_BYTES = 9;
    localparam int BUF_W     = 8 * MAX_BYTES;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    typedef enum logic [3:0] {
        OP_UINT    = 4'd0,
        OP_SINT    = 4'd1,
        OP_DOUBLE  = 4'd2,
        OP_NULL    = 4'd3,
        OP_BOOL    = 4'd4,
        OP_BYTES   = 4'd5,
        OP_TEXT    = 4'd6,
        OP_ARRAY   = 4'd7,
        OP_MAP     = 4'd8,
        OP_TAG     = 4'd9,
        OP_PAYLOAD = 4'd10,
        OP_END     = 4'd11
    } opcode_t;

    // Major types.
    localparam logic [2:0] MAJ_UINT  = 3'd0;
    localparam logic [2:0] MAJ_NINT  = 3'd1;
    localparam logic [2:0] MAJ_BYTES = 3'd2;
    localparam logic [2:0] MAJ_TEXT  = 3'd3;
    localparam logic [2:0] MAJ_ARRAY = 3'd4;
    localparam logic [2:0] MAJ_MAP   = 3'd5;
    localparam logic [2:0] MAJ_TAG   = 3'd6;

    // Additional-information codes for the argument length.
    localparam logic [4:0] AI_ONE   = 5'd24;
    localparam logic [4:0] AI_TWO   = 5'd25;
    localparam logic [4:0] AI_FOUR  = 5'd26;
    localparam logic [4:0] AI_EIGHT = 5'd27;

    // Simple values and float leads.
    localparam logic [7:0] SIMPLE_FALSE = 8'hf4;
    localparam logic [7:0] SIMPLE_TRUE  = 8'hf5;
    localparam logic [7:0] SIMPLE_NULL  = 8'hf6;
    localparam logic [7:0] END_BYTE     = 8'h00;
    localparam logic [7:0] HALF_LEAD    = 8'hf9;
    localparam logic [7:0] DOUBLE_LEAD  = 8'hfb;
    localparam logic [7:0] HALF_POS_INF = 8'h7c;
    localparam logic [7:0] HALF_NAN     = 8'h7e;
    localparam logic [7:0] HALF_NEG_INF = 8'hfc;
    localparam logic [7:0] HALF_LOW     = 8'h00;

    // Encoded token: bytes in emission order, first byte lowest.
    typedef struct packed {
        logic [BUF_W-1:0] bytes;
        logic [CNT_W-1:0] count;
    } enc_t;

endpackage
`default_nettype wire

FILE: sv/cts_encoder.sv
`default_nettype none
// ============================================================================
// CBOR token encoder
// Turns one registered token into its CBOR byte sequence and byte count.
// ============================================================================
module cts_encoder
    import cts_pkg::*;
(
    input  wire logic [3:0]  opcode,
    input  wire logic [63:0] value_bits,
    output enc_t             enc
);

    function automatic enc_t head(input logic [2:0] major, input logic [63:0] arg);
        enc_t r;
        r = '0;
        if (arg < 64'd24) begin
            r.bytes[7:0] = {major, arg[4:0]};
            r.count      = CNT_W'(1);
        end else if (arg <= 64'hff) begin
            r.bytes[7:0]  = {major, AI_ONE};
            r.bytes[15:8] = arg[7:0];
            r.count       = CNT_W'(2);
        end else if (arg <= 64'hffff) begin
            r.bytes[7:0] = {major, AI_TWO};
            for (int k = 0; k < 2; k++) begin
                r.bytes[8*(k+1) +: 8] = arg[8*(1-k) +: 8];
            end
            r.count = CNT_W'(3);
        end else if (arg <= 64'hffff_ffff) begin
            r.bytes[7:0] = {major, AI_FOUR};
            for (int k = 0; k < 4; k++) begin
                r.bytes[8*(k+1) +: 8] = arg[8*(3-k) +: 8];
            end
            r.count = CNT_W'(5);
        end else begin
            r.bytes[7:0] = {major, AI_EIGHT};
            for (int k = 0; k < 8; k++) begin
                r.bytes[8*(k+1) +: 8] = arg[8*(7-k) +: 8];
            end
            r.count = CNT_W'(9);
        end
        return r;
    endfunction

    function automatic enc_t single(input logic [7:0] b);
        enc_t r;
        r = '0;
        r.bytes[7:0] = b;
        r.count      = CNT_W'(1);
        return r;
    endfunction

    function automatic enc_t dbl(input logic [63:0] bits);
        enc_t r;
        r = '0;
        if (bits[62:52] == 11'h7ff) begin
            r.bytes[7:0]   = HALF_LEAD;
            r.bytes[23:16] = HALF_LOW;
            if (bits[51:0] != 52'd0) begin
                r.bytes[15:8] = HALF_NAN;
            end else if (bits[63]) begin
                r.bytes[15:8] = HALF_NEG_INF;
            end else begin
                r.bytes[15:8] = HALF_POS_INF;
            end
            r.count = CNT_W'(3);
        end else begin
            r.bytes[7:0] = DOUBLE_LEAD;
            for (int k = 0; k < 8; k++) begin
                r.bytes[8*(k+1) +: 8] = bits[8*(7-k) +: 8];
            end
            r.count = CNT_W'(9);
        end
        return r;
    endfunction

    always_comb
    begin
        case (opcode_t'(opcode))
            OP_UINT:    enc = head(MAJ_UINT, value_bits);
            OP_SINT:    enc = value_bits[63] ? head(MAJ_NINT, ~value_bits)
                                             : head(MAJ_UINT, value_bits);
            OP_DOUBLE:  enc = dbl(value_bits);
            OP_NULL:    enc = single(SIMPLE_NULL);
            OP_BOOL:    enc = single((value_bits != 64'd0) ? SIMPLE_TRUE : SIMPLE_FALSE);
            OP_BYTES:   enc = head(MAJ_BYTES, value_bits);
            OP_TEXT:    enc = head(MAJ_TEXT, value_bits);
            OP_ARRAY:   enc = head(MAJ_ARRAY, value_bits);
            OP_MAP:     enc = head(MAJ_MAP, value_bits);
            OP_TAG:     enc = head(MAJ_TAG, value_bits);
            OP_PAYLOAD: enc = single(value_bits[7:0]);
            OP_END:     enc = single(END_BYTE);
            default:    enc = '0;   // Unused codes produce no bytes.
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/cts_serializer.sv
`default_nettype none
// ============================================================================
// CBOR byte serialiser
// Output shift register that hands out an encoded token one byte per word.
// ============================================================================
module cts_serializer
    import cts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire enc_t       enc,
    output logic            free,
    output logic [7:0]      m_tdata,
    output logic            m_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready
);

    logic [BUF_W-1:0] buf_reg, buf_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             take;

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = buf_reg[7:0];
    assign m_tlast  = (cnt_reg == CNT_W'(1));
    assign take     = m_tvalid && m_tready;
    // Free once the register is empty or its final byte leaves this cycle.
    assign free     = !m_tvalid || (m_tlast && m_tready);

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load) begin
            buf_next = enc.bytes;
            cnt_next = enc.count;
        end else if (take) begin
            buf_next = {8'h00, buf_reg[BUF_W-1:8]};
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule
`default_nettype wire

FILE: sv/cbor_token_serializer_top.sv
`default_nettype none
// ============================================================================
// CBOR token serialiser, top level
// Encodes one typed token per input word into a stream of CBOR bytes.
// ============================================================================
// Usage
//   The slave channel takes one token per word: the token kind in s_tuser and
//   its operand in s_tdata. The master channel gives one CBOR byte per word in
//   m_tdata, with m_tlast high on the final byte belonging to each token.
//   Tokens with an unused kind code are consumed and produce no bytes.
//   A token accepted into the input register is encoded combinationally
//   and loaded into the output shift register once that is free; its first
//   byte is then presented on the master side. A token has one to nine
//   bytes, and the output shift register sends one byte per cycle while
//   m_tready is high, so single-byte tokens such as payload bytes stream at
//   one word per cycle when neither side stalls. While a long head is sent
//   and a further token waits, s_tready is low until its last byte leaves.
//   Reset (rst_n low, asynchronous) empties the input register and the
//   output shift register; no byte is presented afterwards until a token is
//   accepted.
//   When the receiver stalls, the current byte is held on m_tdata, one more
//   token may be taken into the input register, and then s_tready drops.
// ============================================================================
module cbor_token_serializer_top
    import cts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_tdata: [63:0] value_bits
    input  wire logic [63:0] s_tdata,
    // s_tuser: [3:0] opcode
    input  wire logic [3:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata: [7:0] out_byte
    output logic [7:0]       m_tdata,
    // m_tlast carries last_of_run.
    output logic             m_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready
);

    // Input register holding one token ahead of the serialiser.
    logic        in_valid_reg, in_valid_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic [63:0] value_reg, value_next;

    logic ser_free;
    logic load;
    enc_t enc;

    // The held token moves on as soon as the serialiser has room for it.
    assign load     = in_valid_reg && ser_free;
    assign s_tready = !in_valid_reg || ser_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        opcode_next   = opcode_reg;
        value_next    = value_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            opcode_next   = s_tuser;
            value_next    = s_tdata;
        end else if (load) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opcode_reg <= opcode_next;
        value_reg  <= value_next;
    end

    cts_encoder u_encoder (
        .opcode     (opcode_reg),
        .value_bits (value_reg),
        .enc        (enc)
    );

    cts_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .enc      (enc),
        .free     (ser_free),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

endmodule
`default_nettype wire

FILE: sv/cts_checker.sv
`default_nettype none
// ============================================================================
// CBOR token serialiser checker
// Port-level assertions on the output stream and the input back-pressure.
// ============================================================================
`include "assert_macros.svh"

module cts_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);

    logic stalled;
    assign stalled = m_tvalid && !m_tready;

    // A stalled word is held.
    `ASSERT_NEXT(a_hold_valid, clk, rst_n, stalled, m_tvalid, "valid dropped")
    `ASSERT_NEXT(a_hold_data, clk, rst_n, stalled, $stable(m_tdata) && $stable(m_tlast), "changed")
    // The bytes of one token follow each other without a gap.
    `ASSERT_NEXT(a_run_gapless, clk, rst_n, m_tvalid && m_tready && !m_tlast, m_tvalid, "gap")
    // Back-pressure only comes from pending output.
    `ASSERT_IMPLIES(a_ready_cause, clk, rst_n, !s_tready, m_tvalid, "input stalled with output empty")

endmodule

bind cbor_token_serializer_top cts_checker u_cts_checker (.*);
`default_nettype wire

FILE: verif/testbench.sv
// ============================================================================
// CBOR token serialiser testbench
// Feeds typed tokens into the serialiser, predicts the CBOR byte stream that
// each token must produce, and checks every byte and its end-of-token mark
// as it leaves the master side. Both sides idle at random in two settings of
// three, and the receiver holds off once for a long stretch to fill the block up.
// ============================================================================
module testbench;
    import cts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Sizes of the run.
    localparam int RANDOM_TOKENS = 306;
    localparam int HOLD_AT       = 60;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 40;

    // Undefined token kinds sit above the last defined one.
    localparam logic [3:0] OP_UNUSED_LO = 4'd12;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    typedef struct {
        logic [3:0]  op;
        logic [63:0] value;
    } token_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } cbor_byte_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic [63:0] s_tdata  = '0;
    logic [3:0]  s_tuser  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    token_t     token_queue[$];
    cbor_byte_t cbor_bytes_due[$];
    token_t     next_tok;
    cbor_byte_t due_byte;

    int send_gap_pct    = 23;
    int recv_stall_pct  = 50;
    int tokens_accepted = 0;
    int mismatches      = 0;
    int hold_left       = 0;
    bit hold_started    = 1'b0;

    cbor_token_serializer_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Byte stream predictor
    // ------------------------------------------------------------------------
    function automatic void due(logic [7:0] data, logic last);
        cbor_byte_t b;
        b.data = data;
        b.last = last;
        cbor_bytes_due.push_back(b);
    endfunction

    // A CBOR head: the argument goes in the low five bits when it is below 24,
    // otherwise in the shortest of one, two, four or eight big-endian bytes.
    function automatic void encode_head(logic [2:0] major, logic [63:0] arg);
        int         n;
        logic [4:0] ai;
        if (arg < 64'd24)
        begin
            due({major, arg[4:0]}, 1'b1);
        end
        else
        begin
            if (arg <= 64'hff)
            begin
                ai = AI_ONE;
                n  = 1;
            end
            else if (arg <= 64'hffff)
            begin
                ai = AI_TWO;
                n  = 2;
            end
            else if (arg <= 64'hffff_ffff)
            begin
                ai = AI_FOUR;
                n  = 4;
            end
            else
            begin
                ai = AI_EIGHT;
                n  = 8;
            end
            due({major, ai}, 1'b0);
            for (int k = n - 1; k >= 0; k--)
                due(arg[k*8 +: 8], k == 0);
        end
    endfunction

    // NaN and the infinities shrink to half precision; every other double is
    // sent whole, most significant byte first.
    function automatic void encode_double(logic [63:0] bits);
        logic [7:0] half_high;
        if (bits[62:52] == 11'h7ff)
        begin
            if (bits[51:0] != '0)
                half_high = HALF_NAN;
            else if (bits[63])
                half_high = HALF_NEG_INF;
            else
                half_high = HALF_POS_INF;
            due(HALF_LEAD, 1'b0);
            due(half_high, 1'b0);
            due(HALF_LOW, 1'b1);
        end
        else
        begin
            due(DOUBLE_LEAD, 1'b0);
            for (int k = 7; k >= 0; k--)
                due(bits[k*8 +: 8], k == 0);
        end
    endfunction

    function automatic void encode_token(logic [3:0] op, logic [63:0] v);
        case (op)
            OP_UINT:    encode_head(MAJ_UINT, v);
            OP_SINT:
            begin
                // A negative value carries its bitwise complement as argument.
                if (v[63])
                    encode_head(MAJ_NINT, ~v);
                else
                    encode_head(MAJ_UINT, v);
            end
            OP_DOUBLE:  encode_double(v);
            OP_NULL:    due(SIMPLE_NULL, 1'b1);
            OP_BOOL:    due((v != '0) ? SIMPLE_TRUE : SIMPLE_FALSE, 1'b1);
            OP_BYTES:   encode_head(MAJ_BYTES, v);
            OP_TEXT:    encode_head(MAJ_TEXT, v);
            OP_ARRAY:   encode_head(MAJ_ARRAY, v);
            OP_MAP:     encode_head(MAJ_MAP, v);
            OP_TAG:     encode_head(MAJ_TAG, v);
            OP_PAYLOAD: due(v[7:0], 1'b1);
            OP_END:     due(END_BYTE, 1'b1);
            default:    ; // undefined kinds are swallowed without output
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_token(logic [3:0] op, logic [63:0] value);
        token_t t;
        t.op    = op;
        t.value = value;
        token_queue.push_back(t);
    endfunction

    // Operands spread over every head length, with the size boundaries often.
    function automatic logic [63:0] random_operand();
        case ($urandom_range(6))
            0: return 64'($urandom_range(23));
            1: return 64'(24 + $urandom_range(231));
            2: return 64'($urandom_range(16'hffff));
            3: return {32'h0, 32'($urandom)};
            4: return {32'($urandom), 32'($urandom)};
            5:
            begin
                case ($urandom_range(8))
                    0: return 64'd23;
                    1: return 64'd24;
                    2: return 64'hff;
                    3: return 64'h100;
                    4: return 64'hffff;
                    5: return 64'h1_0000;
                    6: return 64'hffff_ffff;
                    7: return 64'h1_0000_0000;
                    default: return '1;
                endcase
            end
            default: return 64'h1 << $urandom_range(63);
        endcase
    endfunction

    function automatic token_t random_token();
        token_t t;
        int     pick;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            // Raw payload bytes make up most of a real stream.
            t.op    = OP_PAYLOAD;
            t.value = {32'($urandom), 32'($urandom)};
        end
        else if (pick < 40)
        begin
            t.op    = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
            t.value = {32'($urandom), 32'($urandom)};
        end
        else
        begin
            t.op    = 4'($urandom_range(OP_END));
            t.value = random_operand();
            case (t.op)
                OP_SINT:
                    if ($urandom_range(1))
                        t.value = ~t.value;
                OP_DOUBLE:
                    if ($urandom_range(3) == 0)
                    begin
                        // Exponent all ones: an infinity or a NaN of either sign.
                        t.value[62:52] = 11'h7ff;
                        t.value[63]    = 1'($urandom_range(1));
                        if ($urandom_range(1))
                            t.value[51:0] = '0;
                        else
                            t.value[51:0] = {20'($urandom), 32'($urandom)};
                    end
                    else
                    begin
                        t.value = {32'($urandom), 32'($urandom)};
                    end
                OP_BOOL:
                    if ($urandom_range(1))
                        t.value = '0;
                default: ;
            endcase
        end
        return t;
    endfunction

    task automatic wait_tokens_sent();
        while (token_queue.size() != 0 || s_tvalid)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Slave side driver: presents the oldest pending token, holds it until
    // the word is taken, and predicts the bytes of every accepted token.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                encode_token(s_tuser, s_tdata);
                tokens_accepted <= tokens_accepted + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (token_queue.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    next_tok = token_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_tok.value;
                    s_tuser  <= next_tok.op;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started once after a number of tokens are in,
    // so that the block fills up and drops s_tready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left    <= 0;
            hold_started <= 1'b0;
        end
        else if (!hold_started && tokens_accepted >= HOLD_AT)
        begin
            hold_left    <= HOLD_CYCLES;
            hold_started <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Master side monitor: each accepted word against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cbor_bytes_due.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got byte %02h last %0b",
                         $time, m_tdata, m_tlast);
                mismatches++;
            end
            else
            begin
                due_byte = cbor_bytes_due.pop_front();
                if (m_tdata !== due_byte.data)
                begin
                    $display("%0t: byte mismatch, expected %02h, got %02h",
                             $time, due_byte.data, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== due_byte.last)
                begin
                    $display("%0t: last mismatch, expected %0b, got %0b",
                             $time, due_byte.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: directed tokens, then random tokens in three settings, two idling.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Head length boundaries and the signed edge cases.
        queue_token(OP_UINT, 64'd0);
        queue_token(OP_UINT, 64'd23);
        queue_token(OP_UINT, 64'd24);
        queue_token(OP_UINT, 64'hffff_ffff_ffff_ffff);
        queue_token(OP_SINT, 64'hffff_ffff_ffff_ffff);
        queue_token(OP_SINT, 64'h8000_0000_0000_0000);
        queue_token(OP_SINT, 64'hffff_ffff_ffff_ffe7);
        queue_token(OP_SINT, 64'h7fff_ffff_ffff_ffff);
        // Infinities, a negative NaN with a payload, and an ordinary double.
        queue_token(OP_DOUBLE, 64'h7ff0_0000_0000_0000);
        queue_token(OP_DOUBLE, 64'hfff0_0000_0000_0000);
        queue_token(OP_DOUBLE, 64'hfff0_0000_0000_0001);
        queue_token(OP_DOUBLE, 64'h3ff0_0000_0000_0000);
        queue_token(OP_NULL, 64'd0);
        queue_token(OP_BOOL, 64'd0);
        queue_token(OP_BOOL, 64'h8000_0000_0000_0000);
        queue_token(OP_BYTES, 64'hff);
        queue_token(OP_TEXT, 64'h100);
        queue_token(OP_ARRAY, 64'hffff);
        queue_token(OP_MAP, 64'h1_0000);
        queue_token(OP_TAG, 64'hffff_ffff);
        queue_token(OP_TAG, 64'h1_0000_0000);
        queue_token(OP_PAYLOAD, 64'hffff_ffff_ffff_ffa5);
        queue_token(OP_END, 64'hffff_ffff_ffff_ffff);
        queue_token(OP_UNUSED_LO, 64'h1234);
        queue_token(OP_UNUSED_HI, 64'hffff_ffff_ffff_ffff);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_gap_pct   = 23;
                    recv_stall_pct = 50;
                end
                1:
                begin
                    send_gap_pct   = 50;
                    recv_stall_pct = 23;
                end
                default:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int i = 0; i < RANDOM_TOKENS / 3; i++)
                token_queue.push_back(random_token());
            wait_tokens_sent();
        end

        while (cbor_bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #400_000;
        $display("Verification failed");
        $finish;
    end

endmodule
